>>> rtl/chs_pkg.sv
// Shared constants, operation codes and controller/datapath interface types for the hash set.
package chs_pkg;

   localparam int DefaultBucketCount = 64;
   localparam int DefaultNodeCount   = 256;
   localparam int KeyWidth           = 32;
   localparam int TotalWidth         = 9;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_TEST   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic sweep;
      logic take;
      logic head_rd;
      logic head_ld;
      logic node_rd;
      logic node_cmp;
      logic pop;
      logic link;
      logic unlink;
      logic set_hit;
      logic set_full;
      logic out_load;
   } chs_cmd_type;

   typedef struct packed {
      logic     sweep_last;
      logic     hash_done;
      logic     cur_null;
      logic     key_match;
      logic     found;
      logic     pool_empty;
      logic     out_free;
      mode_type mode;
   } chs_status_type;

endpackage

>>> rtl/chs_hash.sv
// Bucket hash unit: magnitude of the key modulo the bucket count.
module chs_hash import chs_pkg::*; #(
   parameter int BUCKET_COUNT = DefaultBucketCount
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [KeyWidth-1:0]              key,
   output logic                             done,
   output logic [$clog2(BUCKET_COUNT)-1:0]  bucket
);

   localparam int BW = $clog2(BUCKET_COUNT);

   logic [KeyWidth-1:0] mag;

   assign mag = key[KeyWidth-1] ? (KeyWidth'(0) - key) : key;

   if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_pow2
      logic          done_ff;
      logic [BW-1:0] bucket_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            bucket_ff <= mag[BW-1:0];
         end
      end

      assign done   = done_ff;
      assign bucket = bucket_ff;
   end else begin : g_recip
      // The quotient comes from a multiplication by a rounded-up reciprocal,
      // which is exact for every 32-bit magnitude; only its low bits are kept.
      localparam int                ShiftAmt  = KeyWidth + BW;
      localparam int                ProdWidth = 2 * KeyWidth + 1;
      localparam logic [63:0]       Recip64   =
         ((64'd1 << ShiftAmt) / 64'(BUCKET_COUNT)) + 64'd1;
      localparam logic [KeyWidth:0] Recip     = Recip64[KeyWidth:0];
      localparam logic [BW-1:0]     DivLow    = BW'(BUCKET_COUNT);

      logic [KeyWidth-1:0]  mag_ff;
      logic [ProdWidth-1:0] prod_ff;
      logic [BW-1:0]        bucket_ff;
      logic                 mag_vld_ff;
      logic                 prod_vld_ff;
      logic                 done_ff;
      logic [BW-1:0]        quot_low;
      logic [BW-1:0]        back_low;

      assign quot_low = prod_ff[ShiftAmt +: BW];
      assign back_low = quot_low * DivLow;

      always_ff @(posedge clock) begin
         if (reset) begin
            mag_vld_ff  <= 1'b0;
            prod_vld_ff <= 1'b0;
            done_ff     <= 1'b0;
         end else begin
            mag_vld_ff  <= start;
            prod_vld_ff <= mag_vld_ff;
            done_ff     <= prod_vld_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            mag_ff <= mag;
         end
         if (mag_vld_ff) begin
            prod_ff <= ProdWidth'(mag_ff) * ProdWidth'(Recip);
         end
         if (prod_vld_ff) begin
            bucket_ff <= mag_ff[BW-1:0] - back_low;
         end
      end

      assign done   = done_ff;
      assign bucket = bucket_ff;
   end

endmodule

>>> rtl/chs_datapath.sv
// Datapath: bucket heads, node pool, free stack, counters and the result register.
module chs_datapath import chs_pkg::*; #(
   parameter int BUCKET_COUNT = DefaultBucketCount,
   parameter int NODE_COUNT   = DefaultNodeCount
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chs_cmd_type           cmd,
   output chs_status_type        st,
   input  logic [1:0]            req_mode,
   input  logic [KeyWidth-1:0]   req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic                  rsp_pool_full,
   output logic [TotalWidth-1:0] rsp_total
);

   localparam int BW         = $clog2(BUCKET_COUNT);
   localparam int NW         = $clog2(NODE_COUNT);
   localparam int IW         = $clog2(NODE_COUNT + 1);
   localparam int SweepCount = (BUCKET_COUNT > NODE_COUNT) ? BUCKET_COUNT : NODE_COUNT;
   localparam int SW         = $clog2(SweepCount);
   localparam logic [IW-1:0] NullIdx = IW'(NODE_COUNT);

   logic [IW-1:0]       bucket_mem [BUCKET_COUNT];
   logic [KeyWidth-1:0] key_mem    [NODE_COUNT];
   logic [IW-1:0]       link_mem   [NODE_COUNT];
   logic [NW-1:0]       free_mem   [NODE_COUNT];

   mode_type            mode_ff;
   logic [KeyWidth-1:0] key_ff;
   logic [IW-1:0]       head_q_ff;
   logic [KeyWidth-1:0] key_q_ff;
   logic [IW-1:0]       link_q_ff;
   logic [NW-1:0]       free_q_ff;
   logic [IW-1:0]       cur_ff;
   logic [IW-1:0]       prev_ff;
   logic [IW-1:0]       head_ff;
   logic [IW-1:0]       next_ff;
   logic                found_ff;
   logic                hit_ff;
   logic                full_ff;
   logic [IW-1:0]       free_top_ff;
   logic [IW-1:0]       free_top_in;
   logic [IW-1:0]       count_ff;
   logic [IW-1:0]       count_in;
   logic [SW-1:0]       sweep_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic                rsp_full_ff;
   logic [TotalWidth-1:0] rsp_total_ff;

   logic [BW-1:0]       bucket;
   logic                hash_done;
   logic                sweep_bucket;
   logic                sweep_node;
   logic                push_ok;
   logic [IW-1:0]       pop_idx;

   logic                bucket_we;
   logic [BW-1:0]       bucket_waddr;
   logic [IW-1:0]       bucket_wdata;
   logic                link_we;
   logic [NW-1:0]       link_waddr;
   logic [IW-1:0]       link_wdata;
   logic                free_we;
   logic [NW-1:0]       free_waddr;
   logic [NW-1:0]       free_wdata;

   chs_hash #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (cmd.take),
      .key   (req_key),
      .done  (hash_done),
      .bucket(bucket)
   );

   assign sweep_bucket = cmd.sweep && ({1'b0, sweep_ff} < (SW + 1)'(BUCKET_COUNT));
   assign sweep_node   = cmd.sweep && ({1'b0, sweep_ff} < (SW + 1)'(NODE_COUNT));
   assign push_ok      = free_top_ff < IW'(NODE_COUNT);
   assign pop_idx      = free_top_ff - IW'(1);

   always_comb begin
      bucket_we    = sweep_bucket || cmd.link || (cmd.unlink && (prev_ff == NullIdx));
      bucket_waddr = bucket;
      bucket_wdata = next_ff;
      priority if (cmd.sweep) begin
         bucket_waddr = sweep_ff[BW-1:0];
         bucket_wdata = NullIdx;
      end else if (cmd.link) begin
         bucket_wdata = IW'(free_q_ff);
      end else begin
         bucket_wdata = next_ff;
      end

      link_we    = cmd.link || (cmd.unlink && (prev_ff != NullIdx));
      link_waddr = cmd.link ? free_q_ff : prev_ff[NW-1:0];
      link_wdata = cmd.link ? head_ff : next_ff;

      free_we    = sweep_node || (cmd.unlink && push_ok);
      free_waddr = cmd.sweep ? sweep_ff[NW-1:0] : free_top_ff[NW-1:0];
      free_wdata = cmd.sweep ? sweep_ff[NW-1:0] : cur_ff[NW-1:0];

      free_top_in = free_top_ff;
      if (cmd.pop) begin
         free_top_in = pop_idx;
      end else if (cmd.unlink && push_ok) begin
         free_top_in = free_top_ff + IW'(1);
      end

      count_in = count_ff;
      if (cmd.link) begin
         count_in = count_ff + IW'(1);
      end else if (cmd.unlink && (count_ff != '0)) begin
         count_in = count_ff - IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (bucket_we) begin
         bucket_mem[bucket_waddr] <= bucket_wdata;
      end
      if (cmd.head_rd) begin
         head_q_ff <= bucket_mem[bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.link) begin
         key_mem[free_q_ff] <= key_ff;
      end
      if (cmd.node_rd) begin
         key_q_ff <= key_mem[cur_ff[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (cmd.node_rd) begin
         link_q_ff <= link_mem[cur_ff[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      if (cmd.pop) begin
         free_q_ff <= free_mem[pop_idx[NW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         free_top_ff  <= IW'(NODE_COUNT);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep && !st.sweep_last) begin
            sweep_ff <= sweep_ff + SW'(1);
         end
         free_top_ff <= free_top_in;
         count_ff    <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         mode_ff  <= mode_type'(req_mode);
         key_ff   <= req_key;
         found_ff <= 1'b0;
         hit_ff   <= 1'b0;
         full_ff  <= 1'b0;
      end
      if (cmd.head_ld) begin
         cur_ff  <= head_q_ff;
         head_ff <= head_q_ff;
         prev_ff <= NullIdx;
      end
      if (cmd.node_cmp) begin
         next_ff <= link_q_ff;
         if (st.key_match) begin
            found_ff <= 1'b1;
         end else begin
            prev_ff <= cur_ff;
            cur_ff  <= link_q_ff;
         end
      end
      if (cmd.link || cmd.unlink || cmd.set_hit) begin
         hit_ff <= 1'b1;
      end
      if (cmd.set_full) begin
         full_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         rsp_hit_ff   <= hit_ff;
         rsp_full_ff  <= full_ff;
         rsp_total_ff <= TotalWidth'(count_ff);
      end
   end

   always_comb begin
      st.sweep_last = sweep_ff == SW'(SweepCount - 1);
      st.hash_done  = hash_done;
      st.cur_null   = cur_ff >= NullIdx;
      st.key_match  = key_q_ff == key_ff;
      st.found      = found_ff;
      st.pool_empty = free_top_ff == '0;
      st.out_free   = !rsp_valid_ff || rsp_ready;
      st.mode       = mode_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_pool_full = rsp_full_ff;
   assign rsp_total     = rsp_total_ff;

endmodule

>>> rtl/chs_ctrl.sv
// Controller state machine: sequences the clearing sweep, hash, chain walk and update.
module chs_ctrl import chs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output chs_cmd_type    cmd,
   input  chs_status_type st
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD,
      ST_CHECK,
      ST_CMP,
      ST_ACT,
      ST_LINK,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (st.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (st.hash_done) begin
               cmd.head_rd = 1'b1;
               state_in    = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cmd.head_ld = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (st.cur_null) begin
               state_in = ST_ACT;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.node_cmp = 1'b1;
            state_in     = st.key_match ? ST_ACT : ST_CHECK;
         end
         ST_ACT: begin
            state_in = ST_DONE;
            unique case (st.mode)
               MODE_ADD: begin
                  if (!st.found) begin
                     if (st.pool_empty) begin
                        cmd.set_full = 1'b1;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = ST_LINK;
                     end
                  end
               end
               MODE_TEST: begin
                  cmd.set_hit = st.found;
               end
               MODE_REMOVE: begin
                  cmd.unlink = st.found;
               end
               default: begin
               end
            endcase
         end
         ST_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/chained_hash_set.sv
// Top level of the chained hash set: stream ports, controller and datapath.
// A set of signed 32-bit keys kept by separate chaining over a node pool.
// After reset the block sweeps its bucket-head and free-stack memories and
// takes no request until that is done. One request is in work at a time: it
// is hashed, the bucket head is read, the chain is walked node by node until
// the key is found or the chain ends, the action is taken, an add that stores
// a key links the new node, and the result is loaded. The block is ready for
// the next request in the cycle after the result is loaded. Bucket counts that
// are not a power of two use the reciprocal-multiply remainder unit, which
// adds the magnitude and product registers. The chain walk reads each node's
// key and link in ST_CHECK and compares the key in ST_CMP. A new request is
// accepted while the previous result waits in the output register.
module chained_hash_set import chs_pkg::*; #(
   parameter int BUCKET_COUNT = DefaultBucketCount,
   parameter int NODE_COUNT   = DefaultNodeCount
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // mode [1:0], key [33:2], zero [39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // hit [0], pool_full [1], element_total [10:2], zero [15:11]
);

   chs_cmd_type           cmd;
   chs_status_type        st;
   logic                  rsp_hit;
   logic                  rsp_pool_full;
   logic [TotalWidth-1:0] rsp_total;

   chs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .cmd      (cmd),
      .st       (st)
   );

   chs_datapath #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .NODE_COUNT  (NODE_COUNT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_mode     (req_tdata[1:0]),
      .req_key      (req_tdata[33:2]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_hit      (rsp_hit),
      .rsp_pool_full(rsp_pool_full),
      .rsp_total    (rsp_total)
   );

   assign rsp_tdata = {5'b0, rsp_total, rsp_pool_full, rsp_hit};

`ifndef ASSERT_OFF
   a_pop_needs_free: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !st.pool_empty)
      else $error("Node popped from an empty free stack.");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !req_tready)
      else $error("Second request accepted while one is in work.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> st.out_free)
      else $error("Result register overwritten before it was taken.");

   a_link_after_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.link |-> $past(cmd.pop))
      else $error("New node linked without a preceding pop.");
`endif

endmodule

>>> verif/tb_top.sv
// Testbench for chained_hash_set: stream stimulus, a set predictor and response checking.
`timescale 1ns / 100ps

module tb_top;
   import chs_pkg::*;

   localparam int BucketCount = DefaultBucketCount;
   localparam int NodeCount   = DefaultNodeCount;
   localparam int KeyPoolSize = 320;
   localparam int LongStall   = 400;

   typedef struct {
      logic       hit;
      logic       pool_full;
      logic [8:0] total;
   } set_result_type;

   class hash_set_scoreboard_type;
      bit [8:0]  head [BucketCount];
      bit [31:0] node_key [NodeCount];
      bit [8:0]  node_link [NodeCount];
      bit [7:0]  free_stack [NodeCount];
      bit [8:0]  free_top;
      bit [8:0]  key_count;
      set_result_type pending_results [$];
      int        mismatch_count;
      int        checked_count;

      function new();
         for (int i = 0; i < BucketCount; i++) head[i] = 9'(NodeCount);
         for (int i = 0; i < NodeCount; i++) free_stack[i] = 8'(i);
         free_top = 9'(NodeCount);
         key_count = '0;
         mismatch_count = 0;
         checked_count = 0;
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      // Applies one accepted request to the shadow set and queues its response.
      function void note_request(mode_type op, logic [31:0] key);
         set_result_type res;
         logic [31:0] mag;
         int unsigned slot, cur, prior, found, steps;
         bit present;
         mag = key[31] ? (~key + 32'd1) : key;
         slot = mag % BucketCount;
         cur = head[slot];
         prior = NodeCount;
         found = 0;
         steps = 0;
         present = 0;
         while (!present && cur < NodeCount && steps < NodeCount) begin
            if (node_key[cur] == key) begin
               present = 1;
               found = cur;
            end else begin
               prior = cur;
               cur = node_link[cur];
               steps++;
            end
         end
         res.hit = 1'b0;
         res.pool_full = 1'b0;
         case (op)
            MODE_ADD: begin
               if (!present) begin
                  if (free_top == 0) begin
                     res.pool_full = 1'b1;
                  end else begin
                     free_top--;
                     found = free_stack[free_top];
                     node_key[found] = key;
                     node_link[found] = head[slot];
                     head[slot] = 9'(found);
                     key_count++;
                     res.hit = 1'b1;
                  end
               end
            end
            MODE_TEST: begin
               res.hit = present;
            end
            MODE_REMOVE: begin
               if (present) begin
                  if (prior == NodeCount) head[slot] = node_link[found];
                  else node_link[prior] = node_link[found];
                  free_stack[free_top] = 8'(found);
                  free_top++;
                  key_count--;
                  res.hit = 1'b1;
               end
            end
            default: ;
         endcase
         res.total = key_count;
         pending_results.push_back(res);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch on response %0d: %s", $realtime, checked_count, what);
         mismatch_count++;
      endtask

      task check_result(logic [15:0] data);
         set_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (data[0] !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", data[0], want.hit));
         if (data[1] !== want.pool_full)
            report_mismatch($sformatf("pool_full %b, expected %b", data[1], want.pool_full));
         if (data[10:2] !== want.total)
            report_mismatch($sformatf("element_total %0d, expected %0d",
                                      data[10:2], want.total));
         checked_count++;
      endtask

      task close_out();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // mode [1:0], key [33:2], zero [39:34]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // hit [0], pool_full [1], element_total [10:2], zero [15:11]

   hash_set_scoreboard_type sb = new();

   int          send_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          long_stall_asks = 0;
   logic [31:0] key_pool [KeyPoolSize];

   chained_hash_set dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("tb_top failed");
      $finish;
   end

   task automatic send_request(input mode_type op, input logic [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, key, op};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, key);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   function automatic mode_type pick_mode(int add_pct, int test_pct, int remove_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < add_pct) return MODE_ADD;
      if (roll < add_pct + test_pct) return MODE_TEST;
      if (roll < add_pct + test_pct + remove_pct) return MODE_REMOVE;
      return MODE_NONE;
   endfunction

   function automatic logic [31:0] pick_key();
      if ($urandom_range(99) < 80) return key_pool[$urandom_range(KeyPoolSize - 1)];
      return $urandom();
   endfunction

   // Response side: checks each accepted response and throttles tready.
   initial begin
      int stall_left;
      int stalls_taken;
      stall_left = 0;
      stalls_taken = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stalls_taken != long_stall_asks) begin
            stalls_taken++;
            stall_left = LongStall;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      int          crowd_slot, start;
      logic [31:0] candidate;
      bit          fresh;

      // Part of the key pool crowds into one bucket to build a long chain.
      crowd_slot = $urandom_range(BucketCount - 1);
      for (int n = 0; n < KeyPoolSize; n++) begin
         do begin
            if (n < 32) begin
               candidate = ($urandom_range(33554431) << 6) | 32'(crowd_slot);
               if ($urandom_range(1)) candidate = -candidate;
            end else begin
               candidate = $urandom();
            end
            fresh = 1'b1;
            for (int m = 0; m < n; m++)
               if (key_pool[m] == candidate) fresh = 1'b0;
         end while (!fresh);
         key_pool[n] = candidate;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      rsp_idle_pct = 63;
      send_request(MODE_ADD, 32'h0000_0000);
      send_request(MODE_ADD, 32'h0000_0000);
      send_request(MODE_TEST, 32'h0000_0000);
      send_request(MODE_ADD, 32'h8000_0000);
      send_request(MODE_ADD, 32'h7FFF_FFFF);
      send_request(MODE_ADD, 32'hFFFF_FFFF);
      send_request(MODE_ADD, 32'h0000_0001);
      send_request(MODE_TEST, 32'hFFFF_FFFF);
      send_request(MODE_TEST, 32'h0000_0001);
      send_request(MODE_TEST, 32'h0000_0005);
      send_request(MODE_REMOVE, 32'h0000_0005);
      send_request(MODE_NONE, 32'h1234_5678);
      send_request(MODE_REMOVE, 32'h0000_0000);
      send_request(MODE_REMOVE, 32'h8000_0000);
      send_request(MODE_ADD, 32'h0000_0040);
      send_request(MODE_ADD, 32'hFFFF_FFC0);
      send_request(MODE_REMOVE, 32'h0000_0040);
      send_request(MODE_TEST, 32'hFFFF_FFC0);
      send_request(MODE_REMOVE, 32'h7FFF_FFFF);
      send_request(MODE_REMOVE, 32'hFFFF_FFFF);
      send_request(MODE_REMOVE, 32'h0000_0001);
      send_request(MODE_REMOVE, 32'hFFFF_FFC0);
      send_request(MODE_TEST, 32'h0000_0000);
      send_request(MODE_NONE, 32'hFFFF_FFFF);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 38;
               rsp_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               rsp_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         // Fill the pool past its capacity so that adds start to be refused.
         start = $urandom_range(KeyPoolSize - 1);
         for (int i = 0; i < KeyPoolSize; i++) begin
            if ($urandom_range(99) < 90)
               send_request(MODE_ADD, key_pool[(start + i) % KeyPoolSize]);
            else
               send_request(pick_mode(25, 40, 30), pick_key());
         end
         if (phase == 0) long_stall_asks++;
         repeat (180) send_request(pick_mode(40, 30, 25), pick_key());
         repeat (180) send_request(pick_mode(10, 15, 70), pick_key());
         drain_results();
      end

      repeat (64) @(posedge clock);
      sb.close_out();
      if (sb.mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/chs_pkg.sv
rtl/chs_hash.sv
rtl/chs_datapath.sv
rtl/chs_ctrl.sv
rtl/chained_hash_set.sv
verif/tb_top.sv
